/* src/rsc_pkg.sv */
// ----------------------------------------------------------------------------
// rsc_pkg
// Types, widths and constants shared by the rotary sin/cos generator.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int POS_W        = 15;
	localparam int IDX_W        = 6;
	localparam int CNT_W        = 7;
	localparam int THETA_W      = 21;
	localparam int VAL_W        = 16;
	localparam int E_W          = 22;
	localparam int N_W          = 6;
	localparam int F_W          = 16;
	localparam int M_W          = 31;
	localparam int T_W          = 39;
	localparam int V_W          = 54;
	localparam int ANG_W        = 24;
	localparam int XY_W         = 34;
	localparam int Z_W          = 25;
	localparam int EXP_STEPS    = 16;
	localparam int CORDIC_STEPS = 20;
	localparam int CFG_IDX_W    = 1;

	localparam int DEF_MAX_POSITIONS = 32768;
	localparam int DEF_MAX_PAIRS     = 64;

	localparam logic [CFG_IDX_W-1:0] CFG_LOG2_THETA = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAIRS      = 1'd1;

	localparam logic [THETA_W-1:0] LOG2_THETA_RST = 21'd870824;
	localparam logic [CNT_W-1:0]   PAIRS_RST      = 7'd32;

	localparam logic [29:0]          TURN_RECIP  = 30'd683565276;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// 2^(-2^-k) in Q.30, built as a chain of floor square roots
	function automatic logic [M_W-1:0] root_const(input int k);
		logic [63:0] c;
		logic [63:0] x;
		logic [30:0] r;
		logic [30:0] cand;
		c = 64'd1 << 29;
		for (int j = 1; j <= k; j++) begin
			x = c << 30;
			r = '0;
			for (int b = 30; b >= 0; b--) begin
				cand = r | (31'd1 << b);
				if (({33'd0, cand} * {33'd0, cand}) <= x)
					r = cand;
			end
			c = {33'd0, r};
		end
		return c[M_W-1:0];
	endfunction

	function automatic logic [21:0] atan_const(input int k);
		logic [21:0] a;
		case (k)
			0:       a = 22'd2097152;
			1:       a = 22'd1238021;
			2:       a = 22'd654136;
			3:       a = 22'd332050;
			4:       a = 22'd166669;
			5:       a = 22'd83416;
			6:       a = 22'd41718;
			7:       a = 22'd20860;
			8:       a = 22'd10430;
			9:       a = 22'd5215;
			10:      a = 22'd2608;
			11:      a = 22'd1304;
			12:      a = 22'd652;
			13:      a = 22'd326;
			14:      a = 22'd163;
			15:      a = 22'd81;
			16:      a = 22'd41;
			17:      a = 22'd20;
			18:      a = 22'd10;
			default: a = 22'd5;
		endcase
		return a;
	endfunction

	// round Q.30 to Q1.15 with saturation
	function automatic logic [VAL_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
		logic signed [XY_W-1:0] r;
		logic [VAL_W-1:0] o;
		r = (v + XY_W'(16384)) >>> 15;
		if (r > XY_W'(32767))
			o = 16'h7FFF;
		else if (r < -XY_W'(32768))
			o = 16'h8000;
		else
			o = r[VAL_W-1:0];
		return o;
	endfunction

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		logic             lst;
		logic [POS_W-1:0] pos;
		logic [N_W-1:0]   n;
		logic [F_W-1:0]   f;
		logic [M_W-1:0]   m;
	} exp_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		logic             lst;
		logic [POS_W-1:0] pos;
		logic [N_W-1:0]   n;
		logic [V_W-1:0]   val;
	} mid_t;

	typedef struct packed {
		logic                   vld;
		logic [IDX_W-1:0]       idx;
		logic                   lst;
		logic [1:0]             quad;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cor_t;

	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] cos_v;
		logic [VAL_W-1:0] sin_v;
		logic             lst;
	} res_t;

endpackage

/* src/rsc_if.sv */
// ----------------------------------------------------------------------------
// rsc_pos_if / rsc_pair_if
// Valid/ready channels for positions and per-pair results.
// ----------------------------------------------------------------------------
interface rsc_pos_if;
	logic        valid;
	logic        ready;
	logic [14:0] position;
	modport source (output valid, output position, input ready);
	modport sink   (input valid, input position, output ready);
endinterface

interface rsc_pair_if;
	logic        valid;
	logic        ready;
	logic [5:0]  pair_index;
	logic [15:0] cos_value;
	logic [15:0] sin_value;
	logic        last;
	modport source (output valid, output pair_index, output cos_value, output sin_value,
		output last, input ready);
	modport sink   (input valid, input pair_index, input cos_value, input sin_value,
		input last, output ready);
endinterface

/* src/rsc_seq.sv */
// ----------------------------------------------------------------------------
// rsc_seq
// Pair sequencer: steps the rounded exponent per pair, with a serial
// divider that refreshes the per-pair increment after reset or a config write.
// ----------------------------------------------------------------------------
module rsc_seq #(
	parameter int MAX_POSITIONS = rsc_pkg::DEF_MAX_POSITIONS,
	parameter int MAX_PAIRS     = rsc_pkg::DEF_MAX_PAIRS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         cfg_we,
	input  logic [rsc_pkg::THETA_W-1:0]  log2_theta,
	input  logic [rsc_pkg::CNT_W-1:0]    pairs_in_use,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rsc_pkg::POS_W-1:0]    position,
	output rsc_pkg::exp_t                stage_s0
);
	import rsc_pkg::*;

	logic               dirty_q, div_run_q, busy_q;
	logic [4:0]         div_cnt_q;
	logic [CNT_W-1:0]   div_rem_q;
	logic [THETA_W-1:0] div_quo_q;
	logic [THETA_W-1:0] lq_q;
	logic [7:0]         lr_q;
	logic [POS_W-1:0]   pos_q;
	logic [IDX_W-1:0]   idx_q;
	logic [CNT_W-1:0]   pcnt_q;
	logic [E_W-1:0]     q_q;
	logic [7:0]         r_q;

	logic [CNT_W-1:0]   pe;
	logic [7:0]         trial;
	logic               qbit;
	logic [CNT_W-1:0]   rem_nx;
	logic [THETA_W-1:0] quo_nx;
	logic               last_issue, accept;
	logic [8:0]         r_sum;
	logic [POS_W-1:0]   pos_clamp;

	always_comb begin
		if (pairs_in_use == '0)
			pe = CNT_W'(1);
		else if (pairs_in_use > CNT_W'(MAX_PAIRS))
			pe = CNT_W'(MAX_PAIRS);
		else
			pe = pairs_in_use;
	end

	assign trial  = {div_rem_q, div_quo_q[THETA_W-1]};
	assign qbit   = trial >= {1'b0, pe};
	assign rem_nx = qbit ? CNT_W'(trial - {1'b0, pe}) : trial[CNT_W-1:0];
	assign quo_nx = {div_quo_q[THETA_W-2:0], qbit};

	assign last_issue = busy_q && (CNT_W'(idx_q) + CNT_W'(1) == pcnt_q);
	assign in_ready   = !dirty_q && (!busy_q || (en && last_issue));
	assign accept     = in_valid && in_ready;
	assign r_sum      = {1'b0, r_q} + {1'b0, lr_q};
	assign pos_clamp  = ({6'd0, position} > 21'(MAX_POSITIONS - 1)) ?
		POS_W'(MAX_POSITIONS - 1) : position;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q   <= 1'b1;
			div_run_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (cfg_we) begin
			dirty_q   <= 1'b1;
			div_run_q <= 1'b0;
		end else if (dirty_q && !div_run_q) begin
			div_run_q <= 1'b1;
			div_cnt_q <= 5'(THETA_W);
		end else if (div_run_q) begin
			div_cnt_q <= div_cnt_q - 5'd1;
			if (div_cnt_q == 5'd1) begin
				div_run_q <= 1'b0;
				dirty_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dirty_q && !div_run_q) begin
			div_quo_q <= log2_theta;
			div_rem_q <= '0;
		end else if (div_run_q) begin
			div_quo_q <= quo_nx;
			div_rem_q <= rem_nx;
			if (div_cnt_q == 5'd1) begin
				lq_q <= quo_nx;
				lr_q <= {rem_nx, 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			stage_s0 <= '0;
		end else begin
			if (en) begin
				stage_s0.vld <= busy_q;
				stage_s0.idx <= idx_q;
				stage_s0.lst <= last_issue;
				stage_s0.pos <= pos_q;
				stage_s0.n   <= q_q[E_W-1:F_W];
				stage_s0.f   <= q_q[F_W-1:0];
				stage_s0.m   <= M_W'(1) << 30;
			end
			if (accept) begin
				busy_q <= 1'b1;
				pos_q  <= pos_clamp;
				idx_q  <= '0;
				q_q    <= '0;
				r_q    <= {1'b0, pe};
				pcnt_q <= pe;
			end else if (en && busy_q) begin
				idx_q <= idx_q + IDX_W'(1);
				if (r_sum >= {1'b0, pcnt_q, 1'b0}) begin
					r_q <= 8'(r_sum - {1'b0, pcnt_q, 1'b0});
					q_q <= q_q + E_W'(lq_q) + E_W'(1);
				end else begin
					r_q <= r_sum[7:0];
					q_q <= q_q + E_W'(lq_q);
				end
				if (last_issue)
					busy_q <= 1'b0;
			end
		end
	end

endmodule

/* src/rsc_exp_cell.sv */
// ----------------------------------------------------------------------------
// rsc_exp_cell
// One exp2 step: scales the mantissa by 2^(-2^-K) when fraction bit is set.
// ----------------------------------------------------------------------------
module rsc_exp_cell #(
	parameter int K = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  rsc_pkg::exp_t d,
	output rsc_pkg::exp_t q
);
	import rsc_pkg::*;

	localparam logic [M_W-1:0] ROOT = root_const(K);

	logic [61:0] prod;
	logic [61:0] rsum;
	exp_t        nx;

	assign prod = 62'(d.m) * 62'(ROOT);
	assign rsum = prod + (62'd1 << 29);

	always_comb begin
		nx = d;
		if (d.f[F_W-K])
			nx.m = rsum[60:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end

endmodule

/* src/rsc_cordic_cell.sv */
// ----------------------------------------------------------------------------
// rsc_cordic_cell
// One CORDIC rotation step with arctangent in Q0.24 turns.
// ----------------------------------------------------------------------------
module rsc_cordic_cell #(
	parameter int K = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  rsc_pkg::cor_t d,
	output rsc_pkg::cor_t q
);
	import rsc_pkg::*;

	localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_const(K));

	logic signed [XY_W-1:0] dx, dy;
	cor_t                   nx;

	assign dx = d.y >>> K;
	assign dy = d.x >>> K;

	always_comb begin
		nx = d;
		if (!d.z[Z_W-1]) begin
			nx.x = d.x - dx;
			nx.y = d.y + dy;
			nx.z = d.z - ATAN;
		end else begin
			nx.x = d.x + dx;
			nx.y = d.y - dy;
			nx.z = d.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end

endmodule

/* src/rope_sin_cos_generator_unit.sv */
// ----------------------------------------------------------------------------
// rope_sin_cos_generator_unit
// Rotary position embedding cos/sin generator.
// ----------------------------------------------------------------------------
// pos_ch takes one token position per item. For each pair i below the
// effective pair count, pair_ch gives pair_index, cos_value and sin_value
// (Q1.15) of position * theta^(-i/P), in ascending order, last on the final.
// Config: cfg_we/cfg_index/cfg_data write log2_theta (0) or pairs_in_use (1)
// while idle.
// Throughput: one pair per cycle while pair_ch accepts; the next
// position is taken as the last pair of the current one is issued.
// After reset or a config write, a serial divide (a load, then 21
// shift-subtract steps) forms the per-pair exponent step; pos_ch.ready
// stays low until it completes.
// From acceptance each pair passes the sequencer, 16 exp2 cells, three
// scaling stages, 20 CORDIC cells and the output register.
// When pair_ch stalls the whole chain holds; nothing is dropped.
// Reset restores log2_theta = 870824 (theta 10000) and 32 pairs.
// ----------------------------------------------------------------------------
module rope_sin_cos_generator_unit #(
	parameter int MAX_POSITIONS = rsc_pkg::DEF_MAX_POSITIONS,
	parameter int MAX_PAIRS     = rsc_pkg::DEF_MAX_PAIRS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rsc_pos_if.sink                       pos_ch,
	rsc_pair_if.source                    pair_ch,
	input  logic                          cfg_we,
	input  logic [rsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rsc_pkg::THETA_W-1:0]   cfg_data
);
	import rsc_pkg::*;

	logic [THETA_W-1:0] log2_theta_q;
	logic [CNT_W-1:0]   pairs_q;
	logic               en;

	exp_t exp_s [EXP_STEPS+1];
	mid_t t_s, v_s;
	cor_t cor_s [CORDIC_STEPS+1];
	res_t out_s;

	logic [60:0]        t_prod;
	logic [V_W-1:0]     v_prod;
	logic [6:0]         sh;
	logic [V_W:0]       rnd;
	logic signed [XY_W-1:0] cx, cy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_theta_q <= LOG2_THETA_RST;
			pairs_q      <= PAIRS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOG2_THETA: log2_theta_q <= cfg_data;
				CFG_PAIRS:      pairs_q      <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !out_s.vld || pair_ch.ready;

	rsc_seq #(.MAX_POSITIONS(MAX_POSITIONS), .MAX_PAIRS(MAX_PAIRS)) u_seq (
		.clk, .arst_n, .en, .cfg_we,
		.log2_theta(log2_theta_q), .pairs_in_use(pairs_q),
		.in_valid(pos_ch.valid), .in_ready(pos_ch.ready), .position(pos_ch.position),
		.stage_s0(exp_s[0])
	);

	for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_exp
		rsc_exp_cell #(.K(k)) u_cell (.clk, .arst_n, .en, .d(exp_s[k-1]), .q(exp_s[k]));
	end

	assign t_prod = 61'(exp_s[EXP_STEPS].m) * 61'(TURN_RECIP) + (61'd1 << 21);
	assign v_prod = V_W'(t_s.pos) * V_W'(t_s.val[T_W-1:0]);
	assign sh     = 7'(v_s.n) + 7'd16;
	assign rnd    = ({1'b0, v_s.val} + ((V_W+1)'(1) << (sh - 7'd1))) >> sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_s      <= '0;
			v_s      <= '0;
			cor_s[0] <= '0;
		end else if (en) begin
			t_s.vld <= exp_s[EXP_STEPS].vld;
			t_s.idx <= exp_s[EXP_STEPS].idx;
			t_s.lst <= exp_s[EXP_STEPS].lst;
			t_s.pos <= exp_s[EXP_STEPS].pos;
			t_s.n   <= exp_s[EXP_STEPS].n;
			t_s.val <= V_W'(t_prod[60:22]);
			v_s.vld <= t_s.vld;
			v_s.idx <= t_s.idx;
			v_s.lst <= t_s.lst;
			v_s.pos <= t_s.pos;
			v_s.n   <= t_s.n;
			v_s.val <= v_prod;
			cor_s[0].vld  <= v_s.vld;
			cor_s[0].idx  <= v_s.idx;
			cor_s[0].lst  <= v_s.lst;
			cor_s[0].quad <= rnd[ANG_W-1:ANG_W-2];
			cor_s[0].x    <= CORDIC_GAIN;
			cor_s[0].y    <= '0;
			cor_s[0].z    <= Z_W'(rnd[ANG_W-3:0]);
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
		rsc_cordic_cell #(.K(k)) u_cell (.clk, .arst_n, .en, .d(cor_s[k]), .q(cor_s[k+1]));
	end

	always_comb begin
		case (cor_s[CORDIC_STEPS].quad)
			2'd0: begin
				cx = cor_s[CORDIC_STEPS].x;
				cy = cor_s[CORDIC_STEPS].y;
			end
			2'd1: begin
				cx = -cor_s[CORDIC_STEPS].y;
				cy = cor_s[CORDIC_STEPS].x;
			end
			2'd2: begin
				cx = -cor_s[CORDIC_STEPS].x;
				cy = -cor_s[CORDIC_STEPS].y;
			end
			default: begin
				cx = cor_s[CORDIC_STEPS].y;
				cy = -cor_s[CORDIC_STEPS].x;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s <= '0;
		end else if (en) begin
			out_s.vld   <= cor_s[CORDIC_STEPS].vld;
			out_s.idx   <= cor_s[CORDIC_STEPS].idx;
			out_s.lst   <= cor_s[CORDIC_STEPS].lst;
			out_s.cos_v <= to_q15(cx);
			out_s.sin_v <= to_q15(cy);
		end
	end

	assign pair_ch.valid      = out_s.vld;
	assign pair_ch.pair_index = out_s.idx;
	assign pair_ch.cos_value  = out_s.cos_v;
	assign pair_ch.sin_value  = out_s.sin_v;
	assign pair_ch.last       = out_s.lst;

endmodule

/* src/rsc_checker.sv */
// ----------------------------------------------------------------------------
// rsc_checker
// Port-level checks on the rotary sin/cos generator.
// ----------------------------------------------------------------------------
module rsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  pair_index,
	input logic        last
);
	logic        first_q;
	logic [5:0]  prev_q;
	logic [7:0]  pend_q;
	logic        in_fire, out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			prev_q  <= '0;
			pend_q  <= '0;
		end else begin
			if (out_fire) begin
				first_q <= last;
				prev_q  <= pair_index;
			end
			pend_q <= pend_q + 8'(in_fire) - 8'(out_fire && last);
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pair_index) && $stable(last))
		else $error("item changed under stall");

	a_index_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !first_q |-> pair_index == prev_q + 6'd1)
		else $error("pair index out of order");

	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && first_q |-> pair_index == 6'd0)
		else $error("first pair not zero");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> pend_q != 8'd0)
		else $error("result without pending position");

endmodule

bind rope_sin_cos_generator_unit rsc_checker u_rsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pos_ch.valid),
	.in_ready   (pos_ch.ready),
	.out_valid  (pair_ch.valid),
	.out_ready  (pair_ch.ready),
	.pair_index (pair_ch.pair_index),
	.last       (pair_ch.last)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rotary sin/cos generator. Positions are pushed
// through a valid/ready channel under several theta and pair-count settings.
// A scoreboard expands each accepted position into its expected per-pair
// cos/sin items and compares every result item in order.
// ----------------------------------------------------------------------------
module tb_top;
	import rsc_pkg::*;

	localparam int WDOG_LIMIT = 4000;
	localparam int DRAIN_GAP  = 60;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] cos_v;
		logic [VAL_W-1:0] sin_v;
		logic             lst;
	} pair_t;

	class rope_table_board;
		logic [THETA_W-1:0] log2_theta;
		logic [CNT_W-1:0]   pairs_cfg;
		pair_t              pending[$];
		int                 errors;
		longint unsigned    roots[17];
		longint             atan_tab[20];

		function new();
			longint unsigned x, res, b;
			atan_tab = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
				20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};
			roots[0] = 64'd1 << 29;
			for (int k = 1; k <= 16; k++) begin
				x = roots[k-1] << 30;
				res = 0;
				b = 64'd1 << 62;
				while (b > x)
					b >>= 2;
				while (b != 0) begin
					if (x >= res + b) begin
						x -= res + b;
						res = (res >> 1) + b;
					end else begin
						res >>= 1;
					end
					b >>= 2;
				end
				roots[k] = res;
			end
			log2_theta = LOG2_THETA_RST;
			pairs_cfg  = PAIRS_RST;
			errors = 0;
		endfunction

		function logic [VAL_W-1:0] q15(longint v);
			longint r;
			r = (v + 16384) >>> 15;
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			return r[VAL_W-1:0];
		endfunction

		function void note_position(logic [POS_W-1:0] p);
			longint unsigned np, e, n, f, m, t, v, s, ang;
			longint x, y, z, dx, dy;
			pair_t pr;
			np = pairs_cfg;
			if (np == 0)
				np = 1;
			if (np > DEF_MAX_PAIRS)
				np = DEF_MAX_PAIRS;
			for (longint unsigned i = 0; i < np; i++) begin
				e = (2 * i * log2_theta + np) / (2 * np);
				n = e >> 16;
				f = e & 16'hFFFF;
				m = 64'd1 << 30;
				for (int k = 1; k <= 16; k++)
					if ((f >> (16 - k)) & 1)
						m = (m * roots[k] + (64'd1 << 29)) >> 30;
				t = (m * 64'd683565276 + (64'd1 << 21)) >> 22;
				v = p * t;
				s = n + 16;
				ang = 0;
				if (s < 62)
					ang = ((v + (64'd1 << (s - 1))) >> s) & 24'hFFFFFF;
				x = 652032874;
				y = 0;
				z = ang & 22'h3FFFFF;
				for (int k = 0; k < 20; k++) begin
					dx = y >>> k;
					dy = x >>> k;
					if (z >= 0) begin
						x -= dx; y += dy; z -= atan_tab[k];
					end else begin
						x += dx; y -= dy; z += atan_tab[k];
					end
				end
				case (ang >> 22)
					0: begin pr.cos_v = q15(x);  pr.sin_v = q15(y);  end
					1: begin pr.cos_v = q15(-y); pr.sin_v = q15(x);  end
					2: begin pr.cos_v = q15(-x); pr.sin_v = q15(-y); end
					default: begin pr.cos_v = q15(y); pr.sin_v = q15(-x); end
				endcase
				pr.idx = i[IDX_W-1:0];
				pr.lst = (i + 1 == np);
				pending.push_back(pr);
			end
		endfunction

		function void check_pair(pair_t got);
			pair_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected item idx=%0d cos=%0d sin=%0d last=%0b",
						got.idx, $signed(got.cos_v), $signed(got.sin_v), got.lst);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp idx=%0d cos=%0d sin=%0d last=%0b got idx=%0d cos=%0d sin=%0d last=%0b",
						want.idx, $signed(want.cos_v), $signed(want.sin_v), want.lst,
						got.idx, $signed(got.cos_v), $signed(got.sin_v), got.lst);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [THETA_W-1:0] cfg_data = '0;
	int src_idle = 16;
	int rcv_idle = 63;
	int stall_cnt = 0;
	rope_table_board board = new();

	rsc_pos_if  pos_if();
	rsc_pair_if pair_if();

	initial begin
		pos_if.valid = 1'b0;
		pos_if.position = '0;
		pair_if.ready = 1'b0;
	end

	always #4 clk = ~clk;

	rope_sin_cos_generator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pos_ch   (pos_if.sink),
		.pair_ch  (pair_if.source),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always @(posedge clk) begin
		pair_t got;
		if (pair_if.valid && pair_if.ready) begin
			got = {pair_if.pair_index, pair_if.cos_value, pair_if.sin_value, pair_if.last};
			board.check_pair(got);
		end
		pair_if.ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if ((pos_if.valid && pos_if.ready) || (pair_if.valid && pair_if.ready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_pos(input logic [POS_W-1:0] p);
		while ($urandom_range(99) < src_idle) begin
			pos_if.valid <= 1'b0;
			@(posedge clk);
		end
		pos_if.valid <= 1'b1;
		pos_if.position <= p;
		do
			@(posedge clk);
		while (!pos_if.ready);
		board.note_position(p);
	endtask

	task automatic drain();
		pos_if.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THETA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_LOG2_THETA)
			board.log2_theta = d;
		else
			board.pairs_cfg = d[CNT_W-1:0];
		@(posedge clk);
	endtask

	function automatic logic [POS_W-1:0] rand_pos();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		if (sel == 2)
			return POS_W'($urandom_range(63));
		return POS_W'($urandom);
	endfunction

	initial begin
		logic [THETA_W-1:0] th;
		logic [THETA_W-1:0] pc;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		send_pos('0);
		send_pos('1);
		send_pos(15'd1);
		send_pos(15'h5555);
		send_pos(15'h2AAA);
		drain();
		// zero theta, one pair
		write_reg(CFG_LOG2_THETA, '0);
		write_reg(CFG_PAIRS, 21'd1);
		send_pos('1);
		send_pos(15'd12345);
		drain();
		// max theta, full pairs
		write_reg(CFG_LOG2_THETA, '1);
		write_reg(CFG_PAIRS, 21'd64);
		send_pos('1);
		send_pos(15'd1);
		drain();
		// zero pair count and oversized counts
		write_reg(CFG_PAIRS, '0);
		send_pos(15'd777);
		drain();
		write_reg(CFG_PAIRS, 21'h1FFF7F);
		send_pos('1);
		drain();
		write_reg(CFG_PAIRS, 21'd65);
		send_pos(15'd32000);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			src_idle = (ph < 3) ? 16 : (ph < 6) ? 63 : 0;
			rcv_idle = (ph < 3) ? 63 : (ph < 6) ? 16 : 0;
			case ($urandom_range(3))
				0: th = LOG2_THETA_RST;
				1: th = THETA_W'($urandom_range(65535));
				default: th = THETA_W'($urandom);
			endcase
			case ($urandom_range(4))
				0: pc = 21'd64;
				1: pc = 21'd1;
				2: pc = THETA_W'($urandom);
				default: pc = THETA_W'($urandom_range(16, 1));
			endcase
			write_reg(CFG_LOG2_THETA, th);
			write_reg(CFG_PAIRS, pc);
			for (int n = 0; n < 23; n++) begin
				if (ph == 4 && n == 11) begin
					pos_if.valid <= 1'b0;
					@(posedge clk);
					while (board.pending.size() != 0)
						@(posedge clk);
				end
				send_pos(rand_pos());
			end
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
